// ===== hdl/akbpd_pkg.sv =====
package akbpd_pkg;

   // Default sizes of the key channels
   localparam int HISTORY_DEPTH_DEF = 16;
   localparam int SAMPLE_BITS_DEF   = 10;

   // Press margin register
   localparam int                   MARGIN_BITS  = 10;
   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 10'd18;

   // Packed key byte: upper six bits fixed, then up and down idle bits
   localparam int                     KEY_CODE_BITS = 8;
   localparam logic [KEY_CODE_BITS-1:0] KEY_CODE_BASE = 8'hFC;

endpackage

// ===== hdl/akbpd_if.sv =====
interface akbpd_req_if #(
   parameter int SAMPLE_BITS = akbpd_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] up_sample;
   logic [SAMPLE_BITS-1:0] down_sample;

   modport source (output valid, up_sample, down_sample, input ready);
   modport sink   (input valid, up_sample, down_sample, output ready);
endinterface

interface akbpd_rsp_if #(
   parameter int SAMPLE_BITS = akbpd_pkg::SAMPLE_BITS_DEF
);
   logic                                   valid;
   logic                                   ready;
   logic                                   up_idle;
   logic                                   down_idle;
   logic [akbpd_pkg::KEY_CODE_BITS-1:0]    key_code;
   logic [SAMPLE_BITS-1:0]                 up_baseline;
   logic [SAMPLE_BITS-1:0]                 down_baseline;

   modport source (output valid, up_idle, down_idle, key_code, up_baseline, down_baseline,
                   input ready);
   modport sink   (input valid, up_idle, down_idle, key_code, up_baseline, down_baseline,
                   output ready);
endinterface

interface akbpd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [akbpd_pkg::MARGIN_BITS-1:0] press_margin;

   modport source (output valid, press_margin, input ready);
   modport sink   (input valid, press_margin, output ready);
endinterface

// ===== hdl/akbpd_ram.sv =====
module akbpd_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/akbpd_chan.sv =====
module akbpd_chan #(
   parameter int HISTORY_DEPTH = akbpd_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_BITS   = akbpd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [SAMPLE_BITS-1:0]            sample,
   input  logic [akbpd_pkg::MARGIN_BITS-1:0] margin,
   output logic                              idle,
   output logic [SAMPLE_BITS-1:0]            baseline_next
);
   import akbpd_pkg::*;

   localparam int POS_BITS   = $clog2(HISTORY_DEPTH);
   localparam int SUM_BITS   = SAMPLE_BITS + POS_BITS;
   localparam int CMP_BITS   = (SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS : MARGIN_BITS;
   // Exact divide by depth: floor(sum * RECIP / 2^DIV_SHIFT) for any sum below 2^SUM_BITS
   localparam int DIV_SHIFT  = SUM_BITS + POS_BITS;
   localparam int RECIP_BITS = SUM_BITS + 2;
   localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << DIV_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
   localparam logic [RECIP_BITS-1:0] RECIP   = RECIP_WIDE[RECIP_BITS-1:0];
   localparam logic [POS_BITS-1:0]   POS_LAST = POS_BITS'(HISTORY_DEPTH - 1);

   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic [POS_BITS-1:0]      pos_ff, pos_in;
   logic [HISTORY_DEPTH-1:0] valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0]   baseline_ff;
   logic [SAMPLE_BITS-1:0]   rd_data;
   logic [SAMPLE_BITS-1:0]   oldest;
   logic [SAMPLE_BITS-1:0]   drop;
   logic                     press;
   logic                     wr_en;
   logic [PROD_BITS-1:0]     prod;

   // The read port always points at the next slot to replace, so the oldest
   // entry is on the RAM output in the next cycle. A write goes to the current
   // slot and the read to the following one, so they never hit the same entry.
   akbpd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff),
      .wr_data (sample),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   always_comb begin
      drop   = baseline_ff - sample;
      press  = (sample < baseline_ff) && (CMP_BITS'(drop) > CMP_BITS'(margin));
      idle   = !press;
      wr_en  = accept && !press;
      // Slots never written read as zero
      oldest = valid_ff[pos_ff] ? rd_data : '0;

      sum_in   = sum_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (wr_en) begin
         sum_in           = sum_ff + SUM_BITS'(sample) - SUM_BITS'(oldest);
         pos_in           = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_BITS'(1);
         valid_in[pos_ff] = 1'b1;
      end

      prod          = PROD_BITS'(sum_in) * PROD_BITS'(RECIP);
      baseline_next = prod[DIV_SHIFT +: SAMPLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         pos_ff      <= '0;
         valid_ff    <= '0;
         baseline_ff <= '0;
      end else begin
         sum_ff      <= sum_in;
         pos_ff      <= pos_in;
         valid_ff    <= valid_in;
         baseline_ff <= baseline_next;
      end
   end

endmodule

// ===== hdl/adc_key_baseline_press_detect_core.sv =====
// Channel   Dir  Handshake        Payload
// --------  ---  ---------------  ---------------------------------------------------
// req_ch    in   valid / ready    up_sample, down_sample
// rsp_ch    out  valid / ready    up_idle, down_idle, key_code, up_baseline, down_baseline
// csr_ch    in   valid / ready    press_margin (ready always high)
//
// One request per cycle while req_ch is ready; its response is registered into the output buffer when it is taken.
// Each key's oldest history sample comes from a registered RAM read that is always
// aimed at the next slot to replace, so the sum and baseline update as each request is taken.
// Reset (synchronous) clears sums, positions, baselines and history valid bits,
// and sets press_margin to 18; no clearing pass runs.
// A two-entry output buffer keeps req_ch ready while one response waits; req_ch
// drops ready only when two responses are held.
module adc_key_baseline_press_detect_core #(
   parameter int HISTORY_DEPTH = akbpd_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_BITS   = akbpd_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   akbpd_req_if.sink   req_ch,
   akbpd_rsp_if.source rsp_ch,
   akbpd_csr_if.sink   csr_ch
);
   import akbpd_pkg::*;

   typedef struct packed {
      logic                   up_idle;
      logic                   down_idle;
      logic [SAMPLE_BITS-1:0] up_baseline;
      logic [SAMPLE_BITS-1:0] down_baseline;
   } rsp_type;

   logic [MARGIN_BITS-1:0] margin_ff;
   logic                   req_acc;
   logic                   rsp_pop;
   rsp_type                new_rsp;
   rsp_type                main_ff, main_in;
   rsp_type                skid_ff, skid_in;
   logic                   main_v_ff, main_v_in;
   logic                   skid_v_ff, skid_v_in;

   // Margin register: write whenever the port offers it
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_ch.valid) begin
         margin_ff <= csr_ch.press_margin;
      end
   end

   assign req_ch.ready = !skid_v_ff;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_pop      = main_v_ff && rsp_ch.ready;

   // One channel per key, each with its own history RAM
   akbpd_chan #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_up (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_acc),
      .sample        (req_ch.up_sample),
      .margin        (margin_ff),
      .idle          (new_rsp.up_idle),
      .baseline_next (new_rsp.up_baseline)
   );

   akbpd_chan #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_down (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_acc),
      .sample        (req_ch.down_sample),
      .margin        (margin_ff),
      .idle          (new_rsp.down_idle),
      .baseline_next (new_rsp.down_baseline)
   );

   // Output buffer: main slot drives the port, skid slot catches a response
   // that arrives while main is stalled
   always_comb begin
      main_v_in = main_v_ff;
      main_in   = main_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (rsp_pop) begin
         if (skid_v_ff) begin
            // advance skid into main
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            main_v_in = req_acc;
            main_in   = new_rsp;
         end
      end else if (req_acc) begin
         if (!main_v_ff) begin
            main_v_in = 1'b1;
            main_in   = new_rsp;
         end else begin
            // hold the new response aside
            skid_v_in = 1'b1;
            skid_in   = new_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid         = main_v_ff;
   assign rsp_ch.up_idle       = main_ff.up_idle;
   assign rsp_ch.down_idle     = main_ff.down_idle;
   assign rsp_ch.key_code      = {KEY_CODE_BASE[KEY_CODE_BITS-1:2],
                                  main_ff.up_idle, main_ff.down_idle};
   assign rsp_ch.up_baseline   = main_ff.up_baseline;
   assign rsp_ch.down_baseline = main_ff.down_baseline;

endmodule

// ===== hdl/akbpd_checker.sv =====
module akbpd_checker #(
   parameter int SAMPLE_BITS = akbpd_pkg::SAMPLE_BITS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                up_idle,
   input logic                                down_idle,
   input logic [akbpd_pkg::KEY_CODE_BITS-1:0] key_code,
   input logic [SAMPLE_BITS-1:0]              up_baseline,
   input logic [SAMPLE_BITS-1:0]              down_baseline
);
   import akbpd_pkg::*;

   // Key byte carries the two idle bits under the fixed upper bits
   a_key_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (key_code == {KEY_CODE_BASE[KEY_CODE_BITS-1:2], up_idle, down_idle}))
      else $error("key_code does not match idle bits");

   // A new response appears only after a request was taken
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_valid && req_ready))
      else $error("response without request");

   // Requests are refused only while a response is backed up
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request refused with empty output");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(up_idle) && $stable(down_idle)
          && $stable(up_baseline) && $stable(down_baseline)))
      else $error("stalled response changed");

endmodule

bind adc_key_baseline_press_detect_core akbpd_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_akbpd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .up_idle       (rsp_ch.up_idle),
   .down_idle     (rsp_ch.down_idle),
   .key_code      (rsp_ch.key_code),
   .up_baseline   (rsp_ch.up_baseline),
   .down_baseline (rsp_ch.down_baseline)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

typedef enum int {
   CH_UP   = 0,
   CH_DOWN = 1
} key_chan_type;

typedef struct {
   logic                                 up_idle;
   logic                                 down_idle;
   logic [akbpd_pkg::KEY_CODE_BITS-1:0]  key_code;
   logic [akbpd_pkg::SAMPLE_BITS_DEF-1:0] up_baseline;
   logic [akbpd_pkg::SAMPLE_BITS_DEF-1:0] down_baseline;
} key_result_type;

class key_press_predictor;
   localparam int SB       = akbpd_pkg::SAMPLE_BITS_DEF;
   localparam int HD       = akbpd_pkg::HISTORY_DEPTH_DEF;
   localparam int SUM_BITS = SB + $clog2(HD);

   logic [SB-1:0]                     ring [2][HD];
   logic [SUM_BITS-1:0]               sum [2];
   int                                pos [2];
   logic [akbpd_pkg::MARGIN_BITS-1:0] margin;
   key_result_type                    pending_keys [$];
   int                                errors;
   int                                checked;
   int                                presses [2];
   int                                margin_hits;

   function new();
      foreach (ring[c, i]) ring[c][i] = '0;
      foreach (sum[c]) begin
         sum[c]     = '0;
         pos[c]     = 0;
         presses[c] = 0;
      end
      margin      = akbpd_pkg::MARGIN_RESET;
      errors      = 0;
      checked     = 0;
      margin_hits = 0;
   endfunction

   function logic [SB-1:0] baseline(key_chan_type ch);
      return SB'(sum[ch] / HD);
   endfunction

   function void set_margin(logic [akbpd_pkg::MARGIN_BITS-1:0] value);
      margin = value;
   endfunction

   function int pending();
      return pending_keys.size();
   endfunction

   // A sample is a press only when it lies strictly more than margin below the baseline
   function logic take_sample(key_chan_type ch, logic [SB-1:0] s);
      logic [SB-1:0] base;
      base = baseline(ch);
      if (s < base && base - s == margin) margin_hits++;
      if (s < base && base - s > margin) begin
         presses[ch]++;
         return 1'b0;
      end
      sum[ch]          = sum[ch] + s - ring[ch][pos[ch]];
      ring[ch][pos[ch]] = s;
      pos[ch]          = (pos[ch] == HD - 1) ? 0 : pos[ch] + 1;
      return 1'b1;
   endfunction

   function void note_request(logic [SB-1:0] up, logic [SB-1:0] dn);
      key_result_type r;
      r.up_idle       = take_sample(CH_UP, up);
      r.down_idle     = take_sample(CH_DOWN, dn);
      r.key_code      = akbpd_pkg::KEY_CODE_BASE | {6'd0, r.up_idle, r.down_idle};
      r.up_baseline   = baseline(CH_UP);
      r.down_baseline = baseline(CH_DOWN);
      pending_keys.push_back(r);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t tb: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   function void check_response(key_result_type got);
      key_result_type want;
      if (pending_keys.size() == 0) begin
         errors++;
         $display("%0t tb: response with no request pending, got key_code %0h", $time,
                  got.key_code);
         return;
      end
      want = pending_keys.pop_front();
      checked++;
      compare_field("up_idle", 32'(want.up_idle), 32'(got.up_idle));
      compare_field("down_idle", 32'(want.down_idle), 32'(got.down_idle));
      compare_field("key_code", 32'(want.key_code), 32'(got.key_code));
      compare_field("up_baseline", 32'(want.up_baseline), 32'(got.up_baseline));
      compare_field("down_baseline", 32'(want.down_baseline), 32'(got.down_baseline));
   endfunction
endclass

module tb;
   import akbpd_pkg::*;

   localparam int SB          = SAMPLE_BITS_DEF;
   localparam int SAMPLE_MAX  = (1 << SB) - 1;
   localparam int MARGIN_MAX  = (1 << MARGIN_BITS) - 1;
   localparam int GAP_MAX     = 14;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 55;
   // Longest correct quiet stretch is a sender gap plus a receiver stall plus the
   // pipeline delay; allow many times that before calling the run hung.
   localparam int STALL_LIMIT = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;

   akbpd_req_if req_ch ();
   akbpd_rsp_if rsp_ch ();
   akbpd_csr_if csr_ch ();

   adc_key_baseline_press_detect_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   key_press_predictor predictor = new();

   bit req_burst;
   bit rsp_burst = 1'b0;
   int level [2];
   int margins_written;
   int idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Monitors: sample every handshake at the rising edge, before the block's
   // own updates land.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         predictor.note_request(req_ch.up_sample, req_ch.down_sample);
      end
   end

   always @(posedge clock) begin
      key_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.up_idle       = rsp_ch.up_idle;
         got.down_idle     = rsp_ch.down_idle;
         got.key_code      = rsp_ch.key_code;
         got.up_baseline   = rsp_ch.up_baseline;
         got.down_baseline = rsp_ch.down_baseline;
         predictor.check_response(got);
      end
   end

   always @(posedge clock) begin
      if (!reset && csr_ch.valid && csr_ch.ready) begin
         predictor.set_margin(csr_ch.press_margin);
      end
   end

   // Watchdog: count cycles in which no channel moves anything
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t tb: watchdog expired, %0d requests still pending", $time,
                     predictor.pending());
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // Draw a per-item wait; burst stretches run back to back with no idling
   function automatic int draw_gap(bit burst);
      return burst ? 0 : int'($urandom_range(0, GAP_MAX));
   endfunction

   function automatic int clamp_sample(int s);
      if (s < 0) return 0;
      if (s > SAMPLE_MAX) return SAMPLE_MAX;
      return s;
   endfunction

   // Aim samples at the interesting spots relative to the live baseline: near the
   // current level, straddling the margin, well into a press, above the baseline,
   // or anywhere at all.
   function automatic logic [SB-1:0] pick_sample(key_chan_type ch);
      int base;
      int m;
      int r;
      int s;
      base = int'(predictor.baseline(ch));
      m    = int'(predictor.margin);
      r    = int'($urandom_range(0, 99));
      if (r < 45)      s = level[ch] + int'($urandom_range(0, 16)) - 8;
      else if (r < 60) s = base - m - 1 + int'($urandom_range(0, 2));
      else if (r < 75) s = base - m - int'($urandom_range(1, 300));
      else if (r < 88) s = base + int'($urandom_range(0, 40));
      else             s = int'($urandom_range(0, SAMPLE_MAX));
      return SB'(clamp_sample(s));
   endfunction

   function automatic int pick_level();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return SAMPLE_MAX;
         default: return int'($urandom_range(200, SAMPLE_MAX));
      endcase
   endfunction

   // Present one request after a random gap and hold it until taken
   task automatic send_pair(input logic [SB-1:0] up, input logic [SB-1:0] dn);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.up_sample   <= up;
      req_ch.down_sample <= dn;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
   endtask

   // Hold off new requests until every outstanding response is back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (predictor.pending() != 0) @(negedge clock);
   endtask

   task automatic write_margin(input logic [MARGIN_BITS-1:0] value);
      csr_ch.valid        <= 1'b1;
      csr_ch.press_margin <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      margins_written++;
   endtask

   function automatic logic [MARGIN_BITS-1:0] margin_for_phase(int phase);
      case (phase)
         0:       return '0;
         1:       return MARGIN_BITS'(MARGIN_MAX);
         2:       return MARGIN_BITS'(1);
         3:       return MARGIN_RESET;
         4:       return MARGIN_BITS'($urandom_range(2, 60));
         6:       return '0;
         7:       return MARGIN_BITS'($urandom_range(100, 400));
         8:       return MARGIN_BITS'(MARGIN_MAX);
         9:       return MARGIN_BITS'($urandom_range(0, 30));
         default: return MARGIN_BITS'($urandom_range(0, MARGIN_MAX));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Receiver: stall ready for a random count before each response, except in
   // burst stretches where ready stays high.
   // ---------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap(rsp_burst);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
         if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.up_sample    = '0;
      req_ch.down_sample  = '0;
      csr_ch.valid        = 1'b0;
      csr_ch.press_margin = '0;
      req_burst           = 1'b0;
      margins_written     = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset margin of 18.
      // Baselines start at zero, so even the extremes are taken.
      send_pair(SB'(0), SB'(SAMPLE_MAX));
      // Fill both rings so both baselines settle at 1000
      repeat (16) send_pair(SB'(1000), SB'(1000));
      // Up drops exactly the margin (taken); down drops one more (press)
      send_pair(SB'(982), SB'(981));
      // Up above its baseline, down at zero: down press only
      send_pair(SB'(SAMPLE_MAX), SB'(0));
      // Up press, down taken
      send_pair(SB'(0), SB'(SAMPLE_MAX));
      // Both pressed
      send_pair(SB'(0), SB'(0));
      send_pair(SB'(SAMPLE_MAX), SB'(SAMPLE_MAX));

      // Random phases: drain, change the margin, then run a batch of samples
      // that follow a per-channel level with presses mixed in.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_responses();
         write_margin(margin_for_phase(phase));
         level[CH_UP]   = pick_level();
         level[CH_DOWN] = pick_level();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            logic [SB-1:0] up;
            logic [SB-1:0] dn;
            if ($urandom_range(0, 39) == 0) level[CH_UP] = pick_level();
            if ($urandom_range(0, 39) == 0) level[CH_DOWN] = pick_level();
            up = pick_sample(CH_UP);
            dn = pick_sample(CH_DOWN);
            send_pair(up, dn);
         end
      end

      // Wind down: wait for the last responses, then idle with no traffic
      drain_responses();
      repeat (8) @(negedge clock);

      $display("tb: %0d responses checked across %0d margin writes, including 0 and %0d",
               predictor.checked, margins_written, MARGIN_MAX);
      $display("tb: %0d up and %0d down presses, %0d samples dropped exactly by the margin",
               predictor.presses[CH_UP], predictor.presses[CH_DOWN],
               predictor.margin_hits);
      if (predictor.errors == 0 && predictor.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule

// ===== adc_key_baseline_press_detect_core.f =====
hdl/akbpd_pkg.sv
hdl/akbpd_if.sv
hdl/akbpd_ram.sv
hdl/akbpd_chan.sv
hdl/adc_key_baseline_press_detect_core.sv
hdl/akbpd_checker.sv
test/tb.sv
